@@ src/dlr_pkg.sv @@
// Shared types, constants and codes for the DDA line rasterizer.
package dlr_pkg;

	localparam int COORD_W        = 15;
	localparam int COLOR_W        = 8;
	localparam int PITCH_W        = 15;
	localparam int ADDR_W         = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 1;
	localparam int COORD_BITS_DEF = 15;
	localparam int CMD_DEPTH_DEF  = 4;
	localparam int OUT_DEPTH_DEF  = 4;

	localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(1024);
	localparam logic [ADDR_W-1:0]  BASE_RESET  = '0;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_PITCH  = 1'b0,
		REG_FRAME_BASE = 1'b1
	} cfg_reg_t;

	// Command from the front part to the back part
	typedef struct packed {
		action_t                    op;
		logic                       last;
		logic [COORD_W-1:0]         org_x;
		logic [COORD_W-1:0]         org_y;
		logic signed [COORD_W:0]    dlt_x;
		logic signed [COORD_W:0]    dlt_y;
		logic [COORD_W-1:0]         steps;
		logic [COLOR_W-1:0]         color;
	} cmd_t;

	// Finished pixel waiting in the output queue
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pix_t;

	typedef struct packed {
		logic [PITCH_W-1:0] row_pitch;
		logic [ADDR_W-1:0]  frame_base;
	} cfg_t;

endpackage

@@ src/dda_line_rasterizer_unit.sv @@
// Top level of the DDA line rasterizer: front, command queue, back, output queue.
//
// Channel   Direction  Handshake             Payload
// ------    ---------  --------------------  -----------------------------------------
// input     in         push / full           action, x_start, y_start, x_end, y_end, color
// result    out        empty / pop           pixel_x, pixel_y, pixel_address, pixel_color, last
// config    in         cfg_we                cfg_idx, cfg_wdata (row_pitch, frame_base)
//
// One request is taken per clock while full is low. After its advance request is accepted, a
// pixel passes the command queue, remainder step, pitch multiply, then the base add on the
// way into the output queue. The single-step remainder update sets the one-pixel-per-clock
// rate while the output queue has room.
// Reset clears the control state and sets row_pitch to 1024, frame_base to 0.
// Stalls on pop back up through the output queue and the command queue to full.
module dda_line_rasterizer_unit
	import dlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int CMD_DEPTH  = CMD_DEPTH_DEF,
	parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input queue side
	input  logic                  push,
	output logic                  full,
	input  logic                  action,
	input  logic [COORD_W-1:0]    x_start,
	input  logic [COORD_W-1:0]    y_start,
	input  logic [COORD_W-1:0]    x_end,
	input  logic [COORD_W-1:0]    y_end,
	input  logic [COLOR_W-1:0]    color,
	// result queue side
	output logic                  empty,
	input  logic                  pop,
	output logic [COORD_W-1:0]    pixel_x,
	output logic [COORD_W-1:0]    pixel_y,
	output logic [ADDR_W-1:0]     pixel_address,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic                  last
);
	localparam int OCNT_W = $clog2(OUT_DEPTH+1);
	localparam int CCNT_W = $clog2(CMD_DEPTH+1);

	cfg_t cfg_q;

	// Configuration registers: the user must write them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_pitch  <= PITCH_RESET;
			cfg_q.frame_base <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_ROW_PITCH:  cfg_q.row_pitch  <= cfg_wdata[PITCH_W-1:0];
				REG_FRAME_BASE: cfg_q.frame_base <= cfg_wdata[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: classify each request, set up lines, drop zero-length starts and steps with no line.
	logic  cmd_wr, cmd_full, cmd_empty, cmd_pop;
	cmd_t  cmd_wdata, cmd_rdata;
	logic [CCNT_W-1:0] cmd_count;

	dlr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.action   (action),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.color    (color),
		.cmd_full (cmd_full),
		.cmd_wr   (cmd_wr),
		.cmd_data (cmd_wdata)
	);

	assign full = cmd_full;

	// Command queue between the two halves.
	dlr_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_wr),
		.wr_data (cmd_wdata),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rdata),
		.count   (cmd_count),
		.full    (cmd_full),
		.empty   (cmd_empty)
	);

	// Back: advance the remainders and form the byte address.
	logic              out_wr, out_full, out_empty;
	pix_t              out_wdata, out_rdata;
	logic [OCNT_W-1:0] out_count;
	logic              out_rd;

	dlr_back #(
		.COORD_BITS(COORD_BITS),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_rdata),
		.cmd_pop   (cmd_pop),
		.out_count (out_count),
		.out_wr    (out_wr),
		.out_data  (out_wdata)
	);

	// Output queue: credit check in the back keeps it from overflowing.
	assign out_rd = pop && !out_empty;

	dlr_fifo #(
		.WIDTH($bits(pix_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr && !out_full),
		.wr_data (out_wdata),
		.rd_en   (out_rd),
		.rd_data (out_rdata),
		.count   (out_count),
		.full    (out_full),
		.empty   (out_empty)
	);

	assign empty         = out_empty;
	assign pixel_x       = out_rdata.x;
	assign pixel_y       = out_rdata.y;
	assign pixel_address = out_rdata.addr;
	assign pixel_color   = out_rdata.color;
	assign last          = out_rdata.last;

endmodule

@@ src/dlr_fifo.sv @@
// Small flip-flop queue with registered storage and an occupancy count.
module dlr_fifo
	import dlr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [WIDTH-1:0]             wr_data,
	input  logic                         rd_en,
	output logic [WIDTH-1:0]             rd_data,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic                         full,
	output logic                         empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (rd_en) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CNT_W'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

endmodule

@@ src/dlr_front.sv @@
// Front part: accept items, set up lines and track the pixel count.
module dlr_front
	import dlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               action,
	input  logic [COORD_W-1:0] x_start,
	input  logic [COORD_W-1:0] y_start,
	input  logic [COORD_W-1:0] x_end,
	input  logic [COORD_W-1:0] y_end,
	input  logic [COLOR_W-1:0] color,
	input  logic               cmd_full,
	output logic               cmd_wr,
	output cmd_t               cmd_data
);
	localparam int CB = COORD_BITS;

	logic          active_q;
	logic [CB-1:0] idx_q;
	logic [CB-1:0] total_q;

	logic                accept, is_start;
	logic [CB-1:0]       xs, ys, xe, ye;
	logic signed [CB:0]  dx, dy;
	logic [CB:0]         ax, ay;
	logic [CB-1:0]       steps;
	logic [CB:0]         k;
	logic                fin;

	always_comb begin
		accept   = push && !cmd_full;
		is_start = (action_t'(action) == ACT_START);
		xs = x_start[CB-1:0];
		ys = y_start[CB-1:0];
		xe = x_end[CB-1:0];
		ye = y_end[CB-1:0];
		dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
		dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
		ax = dx[CB] ? (CB+1)'(-dx) : dx;
		ay = dy[CB] ? (CB+1)'(-dy) : dy;
		steps = (ax > ay) ? ax[CB-1:0] : ay[CB-1:0];
		k   = {1'b0, idx_q} + (CB+1)'(1);
		fin = (k >= {1'b0, total_q});
	end

	always_comb begin
		cmd_data = '0;
		if (is_start) begin
			cmd_data.op    = ACT_START;
			cmd_data.org_x = COORD_W'(xs);
			cmd_data.org_y = COORD_W'(ys);
			cmd_data.dlt_x = (COORD_W+1)'(dx);
			cmd_data.dlt_y = (COORD_W+1)'(dy);
			cmd_data.steps = COORD_W'(steps);
			cmd_data.color = color;
		end else begin
			cmd_data.op   = ACT_STEP;
			cmd_data.last = fin;
		end
		// drop zero-length starts and steps with no line in progress
		cmd_wr = accept && (is_start ? (steps != '0) : active_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			total_q  <= '0;
		end else if (accept) begin
			if (is_start) begin
				active_q <= (steps != '0);
				idx_q    <= '0;
				total_q  <= steps;
			end else if (active_q) begin
				idx_q <= k[CB-1:0];
				if (fin) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ src/dlr_back.sv @@
// Back part: remainder stepping, address pipeline, output queue writes.
module dlr_back
	import dlr_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int OUT_DEPTH  = OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           cmd_empty,
	input  cmd_t                           cmd,
	output logic                           cmd_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           out_wr,
	output pix_t                           out_data
);
	localparam int CB    = COORD_BITS;
	localparam int RW    = CB + 3;
	localparam int CNT_W = $clog2(OUT_DEPTH+1) + 2;
	localparam int PRD_W = PITCH_W + CB;

	// line state
	logic [CB-1:0]        org_x_q, org_y_q;
	logic signed [RW-1:0] dx2_q, dy2_q;
	logic [CB:0]          s2_q;
	logic [CB:0]          rem_x_q, rem_y_q;
	logic signed [CB:0]   off_x_q, off_y_q;
	logic [COLOR_W-1:0]   color_q;

	// pipeline
	logic               v_s1, v_s2;
	logic [CB-1:0]      px_s1, py_s1, px_s2;
	logic [PRD_W-1:0]   prod_s2;
	logic [COLOR_W-1:0] color_s1, color_s2;
	logic               last_s1, last_s2;

	logic               is_step, do_step;
	logic [CNT_W-1:0]   in_flight;
	logic [CB:0]        rem_x_n, rem_y_n;
	logic signed [CB:0] off_x_n, off_y_n;
	logic [CB:0]        px_n, py_n;

	// one correction keeps the remainder in range since |2d| <= 2*steps
	function automatic void step_axis(
		input  logic [CB:0]          rem,
		input  logic signed [RW-1:0] d2,
		input  logic [CB:0]          den,
		input  logic signed [CB:0]   off,
		output logic [CB:0]          rem_n,
		output logic signed [CB:0]   off_n
	);
		logic signed [RW-1:0] sum;
		logic signed [RW-1:0] den_s;
		begin
			den_s = $signed({2'b00, den});
			sum   = $signed({2'b00, rem}) + d2;
			if (sum >= den_s) begin
				rem_n = (CB+1)'(sum - den_s);
				off_n = off + (CB+1)'(1);
			end else if (sum < 0) begin
				rem_n = (CB+1)'(sum + den_s);
				off_n = off - (CB+1)'(1);
			end else begin
				rem_n = (CB+1)'(sum);
				off_n = off;
			end
		end
	endfunction

	always_comb begin
		is_step   = (cmd.op == ACT_STEP);
		in_flight = CNT_W'(out_count) + CNT_W'(v_s1) + CNT_W'(v_s2);
		// hold step commands until the output queue has room for them
		cmd_pop = !cmd_empty && (!is_step || (in_flight < CNT_W'(OUT_DEPTH)));
		do_step = cmd_pop && is_step;
		step_axis(rem_x_q, dx2_q, s2_q, off_x_q, rem_x_n, off_x_n);
		step_axis(rem_y_q, dy2_q, s2_q, off_y_q, rem_y_n, off_y_n);
		px_n = $signed({1'b0, org_x_q}) + off_x_n;
		py_n = $signed({1'b0, org_y_q}) + off_y_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= do_step;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			if (is_step) begin
				rem_x_q <= rem_x_n;
				rem_y_q <= rem_y_n;
				off_x_q <= off_x_n;
				off_y_q <= off_y_n;
			end else begin
				org_x_q <= cmd.org_x[CB-1:0];
				org_y_q <= cmd.org_y[CB-1:0];
				// sign-extend the doubled delta
				dx2_q   <= RW'($signed({cmd.dlt_x[CB:0], 1'b0}));
				dy2_q   <= RW'($signed({cmd.dlt_y[CB:0], 1'b0}));
				s2_q    <= {cmd.steps[CB-1:0], 1'b0};
				rem_x_q <= {1'b0, cmd.steps[CB-1:0]};
				rem_y_q <= {1'b0, cmd.steps[CB-1:0]};
				off_x_q <= '0;
				off_y_q <= '0;
				color_q <= cmd.color;
			end
		end
		px_s1    <= px_n[CB-1:0];
		py_s1    <= py_n[CB-1:0];
		color_s1 <= color_q;
		last_s1  <= cmd.last;
		px_s2    <= px_s1;
		prod_s2  <= PRD_W'(cfg.row_pitch) * PRD_W'(py_s1);
		color_s2 <= color_s1;
		last_s2  <= last_s1;
	end

	logic [CB-1:0] py_s2;
	always_ff @(posedge clk) begin
		py_s2 <= py_s1;
	end

	always_comb begin
		out_wr         = v_s2;
		out_data.x     = COORD_W'(px_s2);
		out_data.y     = COORD_W'(py_s2);
		out_data.addr  = cfg.frame_base + ADDR_W'(prod_s2) + ADDR_W'(px_s2);
		out_data.color = color_s2;
		out_data.last  = last_s2;
	end

endmodule
